// ===== rtl/core/osym_pkg.sv =====
package osym_pkg;

	localparam int DEPTH   = 64;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int NAME_W  = 64;
	localparam int TYPE_W  = 64;
	localparam int POS_W   = 7;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int GRP     = 8;
	localparam int GRP_IW  = $clog2(GRP);
	localparam int NGRP    = (DEPTH + GRP - 1) / GRP;
	localparam int PAD     = NGRP * GRP;
	localparam int S_DATA_W = ((POS_W + NAME_W + TYPE_W + 7) / 8) * 8;
	localparam int M_DATA_W = ((STAT_W + POS_W + TYPE_W + POS_W + 7) / 8) * 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_INS  = 2'd0,
		KIND_DEL  = 2'd1,
		KIND_UPD  = 2'd2,
		KIND_SRCH = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_DEL  = 2'd2,
		CELL_UPD  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [IDX_W-1:0]    sel;
		logic [NAME_W-1:0]   key;
		logic [TYPE_W-1:0]   typ;
		logic [CNT_W-1:0]    count;
	} cell_ctl_t;

	typedef struct packed {
		logic                found;
		logic [IDX_W-1:0]    idx;
		logic [TYPE_W-1:0]   typ;
	} sel_res_t;

endpackage

// ===== rtl/core/ordered_symbol_table_top.sv =====
// Ordered table of up to DEPTH name/type entries kept in a row of cells, one entry
// per cell, with serial numbers equal to positions counted from 1. Each item
// passes in order through a compare step in which every cell compares its name with
// the key, a registered priority tree (group register, then result register) that
// picks the lowest matching position, and a final step in which the cells shift or
// rewrite and the result is loaded, which waits while the output register still
// holds an unread result. A new item is taken only after the last one's result is loaded. The
// output register lets a result wait while the next item is accepted. The table
// starts empty with no clearing pass; only entries below the fill count are ever read.
module ordered_symbol_table_top
	import osym_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // position, key_name, type_word, zero pad
	input  logic [KIND_W-1:0]    s_tuser,   // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata    // status, serial, type_out, entry_count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_GRP,
		S_TREE,
		S_FIN
	} state_t;

	state_t              state_q;
	kind_t               kind_q;
	logic [POS_W-1:0]    pos_q;
	logic [NAME_W-1:0]   key_q;
	logic [TYPE_W-1:0]   typ_q;
	logic [CNT_W-1:0]    count_q;

	logic                m_tvalid_q;
	status_t             status_q;
	logic [POS_W-1:0]    serial_q;
	logic [TYPE_W-1:0]   tout_q;
	logic [POS_W-1:0]    ecount_q;

	cell_ctl_t           ctl;
	sel_res_t            res;
	logic [NAME_W-1:0]   names [DEPTH];
	logic [TYPE_W-1:0]   typs  [DEPTH];
	logic [DEPTH-1:0]    hits;

	logic                accept;
	logic                fire;
	logic [POS_W:0]      pos_x;
	logic [POS_W:0]      cnt_x;
	status_t             st_n;
	logic [POS_W-1:0]    serial_n;
	logic [TYPE_W-1:0]   tout_n;
	logic [CNT_W-1:0]    count_n;
	cell_op_t            op_n;
	logic [IDX_W-1:0]    sel_n;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign fire     = (state_q == S_FIN) && (!m_tvalid_q || m_tready);
	assign pos_x    = {1'b0, pos_q};
	assign cnt_x    = (POS_W + 1)'(count_q);

	always_comb begin
		st_n     = ST_OK;
		serial_n = '0;
		tout_n   = '0;
		count_n  = count_q;
		op_n     = CELL_HOLD;
		sel_n    = IDX_W'(pos_q - POS_W'(1));
		unique case (kind_q)
			KIND_INS: begin
				if (pos_q == '0 || pos_x > cnt_x + (POS_W + 1)'(1)) begin
					st_n = ST_BADPOS;
				end else if (cnt_x >= (POS_W + 1)'(DEPTH)) begin
					st_n = ST_FULL;
				end else begin
					op_n     = CELL_INS;
					serial_n = pos_q;
					tout_n   = typ_q;
					count_n  = count_q + CNT_W'(1);
				end
			end
			KIND_DEL: begin
				if (pos_q == '0 || pos_x > cnt_x) begin
					st_n = ST_BADPOS;
				end else begin
					op_n    = CELL_DEL;
					count_n = count_q - CNT_W'(1);
				end
			end
			KIND_UPD: begin
				sel_n = res.idx;
				if (!res.found) begin
					st_n = ST_NOTFOUND;
				end else begin
					op_n     = CELL_UPD;
					serial_n = POS_W'(res.idx) + POS_W'(1);
					tout_n   = typ_q;
				end
			end
			KIND_SRCH: begin
				sel_n = res.idx;
				if (!res.found) begin
					st_n = ST_NOTFOUND;
				end else begin
					serial_n = POS_W'(res.idx) + POS_W'(1);
					tout_n   = res.typ;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ctl.op    = fire ? op_n : CELL_HOLD;
		ctl.sel   = sel_n;
		ctl.key   = key_q;
		ctl.typ   = typ_q;
		ctl.count = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: state_q <= S_GRP;
				S_GRP: state_q <= S_TREE;
				S_TREE: state_q <= S_FIN;
				S_FIN: begin
					if (fire) begin
						state_q <= S_IDLE;
						count_q <= count_n;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(s_tuser);
			pos_q  <= s_tdata[POS_W-1:0];
			key_q  <= s_tdata[POS_W +: NAME_W];
			typ_q  <= s_tdata[POS_W + NAME_W +: TYPE_W];
		end
		if (fire) begin
			status_q <= st_n;
			serial_q <= serial_n;
			tout_q   <= tout_n;
			ecount_q <= POS_W'(count_n);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [NAME_W-1:0] pn;
		logic [TYPE_W-1:0] pt;
		logic [NAME_W-1:0] nn;
		logic [TYPE_W-1:0] nt;
		if (g == 0) begin : g_first
			assign pn = '0;
			assign pt = '0;
		end else begin : g_mid
			assign pn = names[g-1];
			assign pt = typs[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign nn = '0;
			assign nt = '0;
		end else begin : g_body
			assign nn = names[g+1];
			assign nt = typs[g+1];
		end
		osym_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(g)),
			.ctl       (ctl),
			.prev_name (pn),
			.prev_typ  (pt),
			.next_name (nn),
			.next_typ  (nt),
			.name      (names[g]),
			.typ       (typs[g]),
			.hit       (hits[g])
		);
	end

	osym_sel u_sel (
		.clk  (clk),
		.hit  (hits),
		.typs (typs),
		.res  (res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({ecount_q, tout_q, serial_q, status_q});

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_CMP) && !s_tready)
		else $error("item accepted outside idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op_n == CELL_INS) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow table");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_q == ST_FULL) |-> ecount_q == POS_W'(DEPTH))
		else $error("full reported on table with room");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (serial_q != '0) |-> serial_q <= ecount_q)
		else $error("serial beyond entry count");

endmodule

// ===== rtl/core/osym_cell.sv =====
module osym_cell
	import osym_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [IDX_W-1:0]    idx,
	input  cell_ctl_t           ctl,
	input  logic [NAME_W-1:0]   prev_name,
	input  logic [TYPE_W-1:0]   prev_typ,
	input  logic [NAME_W-1:0]   next_name,
	input  logic [TYPE_W-1:0]   next_typ,
	output logic [NAME_W-1:0]   name,
	output logic [TYPE_W-1:0]   typ,
	output logic                hit
);

	logic [NAME_W-1:0] name_q;
	logic [TYPE_W-1:0] typ_q;
	logic              hit_q;
	logic              live;

	assign live = CNT_W'(idx) < ctl.count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= live && (name_q == ctl.key);
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CELL_INS: begin
				if (idx > ctl.sel) begin
					name_q <= prev_name;
					typ_q  <= prev_typ;
				end else if (idx == ctl.sel) begin
					name_q <= ctl.key;
					typ_q  <= ctl.typ;
				end
			end
			CELL_DEL: begin
				if (idx >= ctl.sel) begin
					name_q <= next_name;
					typ_q  <= next_typ;
				end
			end
			CELL_UPD: begin
				if (idx == ctl.sel) begin
					typ_q <= ctl.typ;
				end
			end
			default: begin
			end
		endcase
	end

	assign name = name_q;
	assign typ  = typ_q;
	assign hit  = hit_q;

endmodule

// ===== rtl/core/osym_sel.sv =====
module osym_sel
	import osym_pkg::*;
(
	input  logic                clk,
	input  logic [DEPTH-1:0]    hit,
	input  logic [TYPE_W-1:0]   typs [DEPTH],
	output sel_res_t            res
);

	logic [PAD-1:0]     hit_pad;
	logic [TYPE_W-1:0]  typ_pad [PAD];

	logic               grp_found  [NGRP];
	logic [GRP_IW-1:0]  grp_idx    [NGRP];
	logic [TYPE_W-1:0]  grp_typ    [NGRP];

	logic               grp_found_s1 [NGRP];
	logic [GRP_IW-1:0]  grp_idx_s1   [NGRP];
	logic [TYPE_W-1:0]  grp_typ_s1   [NGRP];

	sel_res_t           pick;
	sel_res_t           res_s2;

	always_comb begin
		hit_pad = '0;
		hit_pad[DEPTH-1:0] = hit;
		for (int e = 0; e < PAD; e++) begin
			typ_pad[e] = '0;
		end
		for (int e = 0; e < DEPTH; e++) begin
			typ_pad[e] = typs[e];
		end
	end

	// lowest hit within each group of cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_found[g] = 1'b0;
			grp_idx[g]   = '0;
			grp_typ[g]   = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (hit_pad[g*GRP + j]) begin
					grp_found[g] = 1'b1;
					grp_idx[g]   = GRP_IW'(j);
					grp_typ[g]   = typ_pad[g*GRP + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			grp_found_s1[g] <= grp_found[g];
			grp_idx_s1[g]   <= grp_idx[g];
			grp_typ_s1[g]   <= grp_typ[g];
		end
	end

	// lowest group with a hit
	always_comb begin
		pick = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_found_s1[g]) begin
				pick.found = 1'b1;
				pick.idx   = IDX_W'(g * GRP + int'(grp_idx_s1[g]));
				pick.typ   = grp_typ_s1[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		res_s2 <= pick;
	end

	assign res = res_s2;

endmodule
